@@ hdl/lsse_pkg.sv @@
// shared constants and codes for the led strip spi symbol encoder
package lsse_pkg;

  localparam int GRB_W    = 24;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;
  localparam int LEN_W    = 11;
  localparam int SYM_CFG_W = 3;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FILL    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_START   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DRAINED = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_ZERO_LEN = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BUSY     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_DONE     = 2'd3;

  // result kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SYM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SYM  = 2'd2;

  // reset symbol patterns
  localparam logic [SYM_CFG_W-1:0] ONE_SYM_RST  = 3'b110;
  localparam logic [SYM_CFG_W-1:0] ZERO_SYM_RST = 3'b100;

endpackage

@@ hdl/lsse_ram.sv @@
// generic simple dual-port ram with registered read
module lsse_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/lsse_byte_enc.sv @@
// maps a grb pixel to spi symbols and picks one packed byte of the stream
module lsse_byte_enc #(
  parameter int SYMBOL_BITS = 3
) (
  input  logic [lsse_pkg::GRB_W-1:0]       grb_i,
  input  logic [lsse_pkg::SYM_CFG_W-1:0]   one_sym_i,
  input  logic [lsse_pkg::SYM_CFG_W-1:0]   zero_sym_i,
  input  logic [$clog2(3*SYMBOL_BITS)-1:0] byte_idx_i,
  output logic [7:0]                       byte_o
);
  import lsse_pkg::*;

  localparam int SW = GRB_W * SYMBOL_BITS;
  localparam int KW = $clog2(3 * SYMBOL_BITS);

  logic [SYMBOL_BITS+SYM_CFG_W-1:0] one_ext, zero_ext;
  logic [SYMBOL_BITS-1:0]           one_sym, zero_sym;
  logic [SW-1:0]                    stream;
  logic [SW-1:0]                    shifted;
  logic [KW+2:0]                    shamt;

  assign one_ext  = {{SYMBOL_BITS{1'b0}}, one_sym_i};
  assign zero_ext = {{SYMBOL_BITS{1'b0}}, zero_sym_i};
  assign one_sym  = one_ext[SYMBOL_BITS-1:0];
  assign zero_sym = zero_ext[SYMBOL_BITS-1:0];

  // first colour bit (msb of g) becomes the top symbol of the stream
  for (genvar j = 0; j < GRB_W; j++) begin : g_sym
    assign stream[SW-1-j*SYMBOL_BITS -: SYMBOL_BITS] =
        grb_i[GRB_W-1-j] ? one_sym : zero_sym;
  end

  assign shamt   = {byte_idx_i, 3'b000};
  assign shifted = stream << shamt;
  assign byte_o  = shifted[SW-1 -: 8];

endmodule

@@ hdl/led_strip_spi_symbol_encoder.sv @@
// top level of the led strip spi symbol encoder
// Pixel store plus command sequencer for an addressable rgb led strip driven
// over spi. Host commands (tuser) write one pixel, fill a range, start or stop
// a frame, or report that one half of the spi double buffer has drained. Each
// colour bit, msb first in g,r,b order, becomes a SYMBOL_BITS-wide pattern
// (one_symbol or zero_symbol) and the patterns are packed msb first into
// bytes, 3*SYMBOL_BITS bytes per pixel. Pixel slots past the end of the strip
// go out as zero bytes; two more drained events then report frame done.
// After reset the pixel store is swept to zero; no command is taken during
// the sweep (configuration writes still are). A pixel write goes straight
// into the store. A range fill writes its pixels one at a time through the
// single write port of the store. A drained event does one store read per
// pixel slot, each followed by the slot's bytes, one output byte per cycle
// while the output side takes each transfer at once; a start does the slot
// work of both buffer halves.
module led_strip_spi_symbol_encoder #(
  parameter int MAX_PIXELS      = 1024,
  parameter int SYMBOL_BITS     = 3,
  parameter int PIXELS_PER_HALF = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_index[9:0], range_end[19:10], color[43:20], half[44], zero pad
  input  logic [47:0] s_axis_tdata,
  // cmd[2:0]
  input  logic [2:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], half_sel[2], byte_offset[7:3], spi_byte[15:8]
  output logic [15:0] m_axis_tdata,
  // kind[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i
);
  import lsse_pkg::*;

  localparam int AW = $clog2(MAX_PIXELS);
  localparam int PB = 3 * SYMBOL_BITS;           // bytes per pixel
  localparam int HB = PB * PIXELS_PER_HALF;      // bytes per buffer half
  localparam int KW = $clog2(PB);
  localparam int OW = $clog2(HB);
  localparam int IW = (PIXELS_PER_HALF > 1) ? $clog2(PIXELS_PER_HALF) : 1;

  // sequencer states
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_FILL   = 3'd2;
  localparam logic [2:0] ST_STATUS = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  // frame phases
  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_SEND      = 2'd1;
  localparam logic [1:0] PH_FILL_END  = 2'd2;
  localparam logic [1:0] PH_WAIT_STOP = 2'd3;

  // input fields
  logic [CMD_W-1:0] in_cmd;
  logic [9:0]       in_pidx, in_rend;
  logic [GRB_W-1:0] in_color, in_grb;
  logic             in_half;

  assign in_cmd   = s_axis_tuser;
  assign in_pidx  = s_axis_tdata[9:0];
  assign in_rend  = s_axis_tdata[19:10];
  assign in_color = s_axis_tdata[43:20];
  assign in_half  = s_axis_tdata[44];
  // stored as g,r,b
  assign in_grb   = {in_color[15:8], in_color[23:16], in_color[7:0]};

  // configuration registers
  logic [LEN_W-1:0]     len_reg_q;
  logic [SYM_CFG_W-1:0] one_sym_q, zero_sym_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_reg_q  <= '0;
      one_sym_q  <= ONE_SYM_RST;
      zero_sym_q <= ZERO_SYM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STRIP_LEN: len_reg_q  <= cfg_data_i;
        REG_ONE_SYM:   one_sym_q  <= cfg_data_i[SYM_CFG_W-1:0];
        REG_ZERO_SYM:  zero_sym_q <= cfg_data_i[SYM_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // strip length clamped to the store size
  logic [LEN_W-1:0] eff_len, len_m1, fill_end;
  logic [LEN_W-1:0] pidx_w, rend_w;

  assign eff_len  = (32'(len_reg_q) > 32'(MAX_PIXELS)) ? LEN_W'(MAX_PIXELS) : len_reg_q;
  assign len_m1   = eff_len - LEN_W'(1);
  assign pidx_w   = {1'b0, in_pidx};
  assign rend_w   = {1'b0, in_rend};
  assign fill_end = (rend_w >= eff_len) ? len_m1 : rend_w;

  // sequencer registers
  logic [2:0]       state_q, state_d;
  logic [1:0]       phase_q, phase_d;
  logic [LEN_W-1:0] next_pixel_q, next_pixel_d;
  logic [LEN_W-1:0] final_pixel_q, final_pixel_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [LEN_W-1:0] fptr_q, fptr_d;
  logic [LEN_W-1:0] fend_q, fend_d;
  logic [GRB_W-1:0] fcolor_q, fcolor_d;
  logic [STATUS_W-1:0] stat_q, stat_d;
  logic             half_q, half_d;
  logic             pend_q, pend_d;    // second half still owed after a start
  logic [IW-1:0]    slot_q, slot_d;
  logic [KW-1:0]    k_q, k_d;
  logic [OW-1:0]    off_q, off_d;
  logic             zslot_q, zslot_d;  // current slot lies past the last pixel

  // output register
  logic                m_valid_q, m_valid_d;
  logic                o_kind_q, o_kind_d;
  logic [STATUS_W-1:0] o_status_q, o_status_d;
  logic                o_half_q, o_half_d;
  logic [4:0]          o_off_q, o_off_d;
  logic [7:0]          o_byte_q, o_byte_d;
  logic                o_last_q, o_last_d;

  // pixel store ports
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [GRB_W-1:0] ram_wdata, ram_rdata;

  // address extension to the store width
  logic [AW+LEN_W-1:0] pidx_ext, fptr_ext, np_ext;
  logic [OW+4:0]       off_ext;

  assign pidx_ext = {{AW{1'b0}}, pidx_w};
  assign fptr_ext = {{AW{1'b0}}, fptr_q};
  assign np_ext   = {{AW{1'b0}}, next_pixel_q};
  assign off_ext  = {5'b00000, off_q};

  logic       accept, out_free, past_end;
  logic [7:0] enc_byte;

  assign accept   = s_axis_tvalid && (state_q == ST_IDLE);
  assign out_free = !m_valid_q || m_axis_tready;
  assign past_end = (next_pixel_q > final_pixel_q) ||
                    (32'(next_pixel_q) >= 32'(MAX_PIXELS));

  lsse_ram #(
    .WIDTH (GRB_W),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lsse_byte_enc #(
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_enc (
    .grb_i      (ram_rdata),
    .one_sym_i  (one_sym_q),
    .zero_sym_i (zero_sym_q),
    .byte_idx_i (k_q),
    .byte_o     (enc_byte)
  );

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    next_pixel_d  = next_pixel_q;
    final_pixel_d = final_pixel_q;
    clr_d         = clr_q;
    fptr_d        = fptr_q;
    fend_d        = fend_q;
    fcolor_d      = fcolor_q;
    stat_d        = stat_q;
    half_d        = half_q;
    pend_d        = pend_q;
    slot_d        = slot_q;
    k_d           = k_q;
    off_d         = off_q;
    zslot_d       = zslot_q;

    m_valid_d  = m_valid_q && !m_axis_tready;
    o_kind_d   = o_kind_q;
    o_status_d = o_status_q;
    o_half_d   = o_half_q;
    o_off_d    = o_off_q;
    o_byte_d   = o_byte_q;
    o_last_d   = o_last_q;

    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = np_ext[AW-1:0];

    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_q == AW'(MAX_PIXELS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end

      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_WRITE: begin
              if (pidx_w < eff_len) begin
                ram_we    = 1'b1;
                ram_waddr = pidx_ext[AW-1:0];
                ram_wdata = in_grb;
              end
            end
            CMD_FILL: begin
              if (eff_len != '0 && pidx_w <= fill_end) begin
                fptr_d   = pidx_w;
                fend_d   = fill_end;
                fcolor_d = in_grb;
                state_d  = ST_FILL;
              end
            end
            CMD_START: begin
              if (eff_len == '0) begin
                stat_d  = STAT_ZERO_LEN;
                state_d = ST_STATUS;
              end else if (phase_q != PH_IDLE) begin
                stat_d  = STAT_BUSY;
                state_d = ST_STATUS;
              end else begin
                next_pixel_d  = '0;
                final_pixel_d = len_m1;
                phase_d       = PH_SEND;
                half_d        = 1'b0;
                pend_d        = 1'b1;
                slot_d        = '0;
                k_d           = '0;
                off_d         = '0;
                state_d       = ST_READ;
              end
            end
            CMD_STOP: begin
              phase_d       = PH_IDLE;
              next_pixel_d  = '0;
              final_pixel_d = '0;
              stat_d        = STAT_DONE;
              state_d       = ST_STATUS;
            end
            CMD_DRAINED: begin
              case (phase_q)
                PH_SEND: begin
                  half_d  = in_half;
                  pend_d  = 1'b0;
                  slot_d  = '0;
                  k_d     = '0;
                  off_d   = '0;
                  state_d = ST_READ;
                end
                PH_FILL_END: begin
                  phase_d = PH_WAIT_STOP;
                  stat_d  = STAT_ACCEPTED;
                  state_d = ST_STATUS;
                end
                PH_WAIT_STOP: begin
                  phase_d       = PH_IDLE;
                  next_pixel_d  = '0;
                  final_pixel_d = '0;
                  stat_d        = STAT_DONE;
                  state_d       = ST_STATUS;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end

      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fptr_ext[AW-1:0];
        ram_wdata = fcolor_q;
        if (fptr_q == fend_q) begin
          state_d = ST_IDLE;
        end else begin
          fptr_d = fptr_q + LEN_W'(1);
        end
      end

      ST_STATUS: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          o_kind_d   = KIND_STATUS;
          o_status_d = stat_q;
          o_half_d   = 1'b0;
          o_off_d    = '0;
          o_byte_d   = '0;
          o_last_d   = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      ST_READ: begin
        // slot past the end sends zeros and ends the pixel data
        if (past_end) begin
          zslot_d = 1'b1;
          phase_d = PH_FILL_END;
        end else begin
          zslot_d      = 1'b0;
          ram_re       = 1'b1;
          next_pixel_d = next_pixel_q + LEN_W'(1);
        end
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          o_kind_d   = KIND_BYTE;
          o_status_d = STAT_ACCEPTED;
          o_half_d   = half_q;
          o_off_d    = off_ext[4:0];
          o_byte_d   = zslot_q ? 8'h00 : enc_byte;
          o_last_d   = (k_q == KW'(PB - 1)) && (slot_q == IW'(PIXELS_PER_HALF - 1)) &&
                       !pend_q;
          off_d      = off_q + OW'(1);
          if (k_q == KW'(PB - 1)) begin
            k_d = '0;
            if (slot_q == IW'(PIXELS_PER_HALF - 1)) begin
              slot_d = '0;
              off_d  = '0;
              if (pend_q) begin
                pend_d  = 1'b0;
                half_d  = 1'b1;
                state_d = ST_READ;
              end else begin
                state_d = ST_IDLE;
              end
            end else begin
              slot_d  = slot_q + IW'(1);
              state_d = ST_READ;
            end
          end else begin
            k_d = k_q + KW'(1);
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      phase_q       <= PH_IDLE;
      next_pixel_q  <= '0;
      final_pixel_q <= '0;
      clr_q         <= '0;
      pend_q        <= 1'b0;
      slot_q        <= '0;
      k_q           <= '0;
      off_q         <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      phase_q       <= phase_d;
      next_pixel_q  <= next_pixel_d;
      final_pixel_q <= final_pixel_d;
      clr_q         <= clr_d;
      pend_q        <= pend_d;
      slot_q        <= slot_d;
      k_q           <= k_d;
      off_q         <= off_d;
      m_valid_q     <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    fptr_q     <= fptr_d;
    fend_q     <= fend_d;
    fcolor_q   <= fcolor_d;
    stat_q     <= stat_d;
    half_q     <= half_d;
    zslot_q    <= zslot_d;
    o_kind_q   <= o_kind_d;
    o_status_q <= o_status_d;
    o_half_q   <= o_half_d;
    o_off_q    <= o_off_d;
    o_byte_q   <= o_byte_d;
    o_last_q   <= o_last_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {o_byte_q, o_off_q, o_half_q, o_status_q};
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tlast  = o_last_q;

  // nothing leaves the block while the store is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !m_valid_q)
    else $error("result valid during store clear");

  // the store is never read and written in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("pixel store read and write collide");

  // the frame pointer never runs more than one past the last pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, next_pixel_q} <= ({1'b0, final_pixel_q} + 12'd1)))
    else $error("next pixel overran final pixel");

  // a status word is always the only result of its command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (o_kind_q == KIND_STATUS)) |-> o_last_q)
    else $error("status word without last");

endmodule

@@ test/led_strip_spi_symbol_encoder_checker.sv @@
// checker for the led strip spi symbol encoder: predicts every result and compares
`timescale 1ns / 1ps

module led_strip_spi_symbol_encoder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // pixel_index[9:0], range_end[19:10], color[43:20], half[44], zero pad
  input  logic [47:0] s_axis_tdata,
  // cmd[2:0]
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], half_sel[2], byte_offset[7:3], spi_byte[15:8]
  input  logic [15:0] m_axis_tdata,
  // kind[0]
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  output int          pending_o,
  output int          errors_o,
  output int          cmds_o,
  output int          bytes_o,
  output int          statuses_o
);
  import lsse_pkg::*;

  localparam int STORE_DEPTH    = 1024;
  localparam int SLOT_BYTES     = 9;
  localparam int SLOTS_PER_HALF = 2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEND,
    PH_FILL_END,
    PH_WAIT_STOP
  } frame_phase_e;

  typedef struct packed {
    logic                kind;
    logic [STATUS_W-1:0] status;
    logic                half_sel;
    logic [4:0]          byte_offset;
    logic [7:0]          spi_byte;
    logic                last;
  } led_result_t;

  logic [GRB_W-1:0]     grb_store [STORE_DEPTH];
  frame_phase_e         frame_phase;
  logic [LEN_W-1:0]     next_slot_pixel;
  logic [LEN_W-1:0]     final_frame_pixel;
  logic [LEN_W-1:0]     strip_len;
  logic [SYM_CFG_W-1:0] one_pat;
  logic [SYM_CFG_W-1:0] zero_pat;
  led_result_t          expected_q [$];
  led_result_t          seen_result;
  int                   err_cnt = 0;
  int                   cmd_cnt = 0;
  int                   byte_cnt = 0;
  int                   stat_cnt = 0;

  task automatic report_error(input string msg);
    err_cnt++;
    $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s got %0h expected %0h", byte_cnt + stat_cnt, name,
                             got, want));
  endtask

  function automatic int active_len();
    return (strip_len > STORE_DEPTH) ? STORE_DEPTH : int'(strip_len);
  endfunction

  // each colour bit becomes one 3-bit pattern, msb first, 72 bits per pixel
  function automatic logic [71:0] symbol_stream(input logic [GRB_W-1:0] grb,
                                                input logic [2:0] one, input logic [2:0] zero);
    logic [71:0] bits;
    bits = '0;
    for (int b = 0; b < GRB_W; b++) bits[71 - 3*b -: 3] = grb[GRB_W-1-b] ? one : zero;
    return bits;
  endfunction

  task automatic store_pixel(input int idx, input logic [GRB_W-1:0] rgb);
    if (idx < active_len()) grb_store[idx] = {rgb[15:8], rgb[23:16], rgb[7:0]};
  endtask

  task automatic queue_result(input logic kind, input logic [STATUS_W-1:0] status,
                              input logic hsel, input logic [4:0] offset, input logic [7:0] data);
    led_result_t r;
    r = {kind, status, hsel, offset, data, 1'b0};
    expected_q.push_back(r);
  endtask

  task automatic queue_status(input logic [STATUS_W-1:0] status);
    queue_result(KIND_STATUS, status, 1'b0, '0, '0);
  endtask

  task automatic load_half(input logic hsel);
    logic [71:0] bits;
    for (int s = 0; s < SLOTS_PER_HALF; s++) begin
      if (next_slot_pixel > final_frame_pixel || next_slot_pixel >= STORE_DEPTH) begin
        // slot past the end of the strip goes out as zeros
        bits = '0;
        frame_phase = PH_FILL_END;
      end else begin
        bits = symbol_stream(grb_store[next_slot_pixel[9:0]], one_pat, zero_pat);
        next_slot_pixel = next_slot_pixel + 1'b1;
      end
      for (int k = 0; k < SLOT_BYTES; k++)
        queue_result(KIND_BYTE, '0, hsel, 5'(s * SLOT_BYTES + k), bits[71 - 8*k -: 8]);
    end
  endtask

  task automatic predict_command(input logic [CMD_W-1:0] cmd, input logic [9:0] pidx,
                                 input logic [9:0] rend, input logic [GRB_W-1:0] color,
                                 input logic hsel);
    int          queued_at_entry;
    int          len;
    int          last_idx;
    led_result_t r;
    queued_at_entry = expected_q.size();
    len = active_len();
    case (cmd)
      CMD_WRITE: store_pixel(int'(pidx), color);
      CMD_FILL: begin
        if (len != 0) begin
          last_idx = (int'(rend) >= len) ? len - 1 : int'(rend);
          for (int i = int'(pidx); i <= last_idx; i++) store_pixel(i, color);
        end
      end
      CMD_START: begin
        if (len == 0) begin
          queue_status(STAT_ZERO_LEN);
        end else if (frame_phase != PH_IDLE) begin
          queue_status(STAT_BUSY);
        end else begin
          next_slot_pixel = '0;
          final_frame_pixel = LEN_W'(len - 1);
          frame_phase = PH_SEND;
          load_half(1'b0);
          load_half(1'b1);
        end
      end
      CMD_STOP: begin
        frame_phase = PH_IDLE;
        next_slot_pixel = '0;
        final_frame_pixel = '0;
        queue_status(STAT_DONE);
      end
      CMD_DRAINED: begin
        case (frame_phase)
          PH_SEND: load_half(hsel);
          PH_FILL_END: begin
            frame_phase = PH_WAIT_STOP;
            queue_status(STAT_ACCEPTED);
          end
          PH_WAIT_STOP: begin
            frame_phase = PH_IDLE;
            next_slot_pixel = '0;
            final_frame_pixel = '0;
            queue_status(STAT_DONE);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (expected_q.size() > queued_at_entry) begin
      r = expected_q.pop_back();
      r.last = 1'b1;
      expected_q.push_back(r);
    end
  endtask

  task automatic check_result(input led_result_t got);
    led_result_t want;
    if (expected_q.size() == 0) begin
      report_error($sformatf("transfer with nothing expected: kind %0b data %h last %0b",
                             got.kind, {got.spi_byte, got.byte_offset, got.half_sel,
                             got.status}, got.last));
    end else begin
      want = expected_q.pop_front();
      check_field("kind", 8'(got.kind), 8'(want.kind));
      check_field("status", 8'(got.status), 8'(want.status));
      check_field("half_sel", 8'(got.half_sel), 8'(want.half_sel));
      check_field("byte_offset", 8'(got.byte_offset), 8'(want.byte_offset));
      check_field("spi_byte", got.spi_byte, want.spi_byte);
      check_field("last", 8'(got.last), 8'(want.last));
    end
    if (got.kind == KIND_STATUS) stat_cnt++;
    else byte_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (grb_store[i]) grb_store[i] = '0;
      frame_phase = PH_IDLE;
      next_slot_pixel = '0;
      final_frame_pixel = '0;
      strip_len = '0;
      one_pat = ONE_SYM_RST;
      zero_pat = ZERO_SYM_RST;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_STRIP_LEN: strip_len = cfg_data_i;
          REG_ONE_SYM:   one_pat = cfg_data_i[SYM_CFG_W-1:0];
          REG_ZERO_SYM:  zero_pat = cfg_data_i[SYM_CFG_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        cmd_cnt++;
        predict_command(s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[19:10],
                        s_axis_tdata[43:20], s_axis_tdata[44]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen_result = {m_axis_tuser, m_axis_tdata[1:0], m_axis_tdata[2], m_axis_tdata[7:3],
                       m_axis_tdata[15:8], m_axis_tlast};
        check_result(seen_result);
      end
    end
    pending_o  <= expected_q.size();
    errors_o   <= err_cnt;
    cmds_o     <= cmd_cnt;
    bytes_o    <= byte_cnt;
    statuses_o <= stat_cnt;
  end

endmodule

@@ test/led_strip_spi_symbol_encoder_tb.sv @@
// top of the led strip spi symbol encoder testbench: stimulus, stalls and verdict
`timescale 1ns / 1ps

module led_strip_spi_symbol_encoder_tb;
  import lsse_pkg::*;

  // receiver hold-off long enough to back the block up into its command input
  localparam int HOLD_CYCLES  = 400;
  // longest quiet stretch of the block: a range fill over the whole store
  localparam int SETTLE_CYCLES = 1100;
  localparam int NUM_PHASES    = 12;
  localparam int PHASE_ITEMS   = 33;

  logic        clk_i;
  logic        rst_ni = 1'b0;

  // command stream into the block
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // pixel_index[9:0], range_end[19:10], color[43:20], half[44], zero pad
  logic [47:0] s_axis_tdata = '0;
  // cmd[2:0]
  logic [2:0]  s_axis_tuser = CMD_WRITE;

  // result stream out of the block
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // status[1:0], half_sel[2], byte_offset[7:3], spi_byte[15:8]
  logic [15:0] m_axis_tdata;
  // kind[0]
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // register writes
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = REG_STRIP_LEN;
  logic [10:0] cfg_data_i = '0;

  // feedback from the checker
  int pending_results;
  int error_total;
  int cmd_total;
  int byte_total;
  int status_total;

  // stall control, percent of cycles idle on each side
  int tx_idle_pct = 10;
  int rx_idle_pct = 64;
  // the stimulus bumps the ticket, the receiver serves it with one long hold-off
  int hold_ticket = 0;
  int hold_served = 0;
  int hold_left = 0;

  int items_sent = 0;
  int settings_used = 0;

  led_strip_spi_symbol_encoder uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  led_strip_spi_symbol_encoder_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending_results),
    .errors_o     (error_total),
    .cmds_o       (cmd_total),
    .bytes_o      (byte_total),
    .statuses_o   (status_total)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stalls, or one long hold-off when the stimulus asks for it
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_ticket != hold_served) begin
      hold_served <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // one command transfer; tvalid stays up on return so back-to-back items need no gap
  task automatic send_cmd(input logic [2:0] cmd, input logic [9:0] pidx, input logic [9:0] rend,
                          input logic [23:0] color, input logic hsel);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {3'b000, hsel, color, rend, pidx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd <= CMD_DRAINED) items_sent++;
  endtask

  // registers only change once the block has nothing left to say and has settled
  task automatic set_registers(input logic [10:0] len, input logic [2:0] one,
                               input logic [2:0] zero);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    // writes and fills give no result but may still be running
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_STRIP_LEN;
    cfg_data_i <= len;
    @(posedge clk_i);
    cfg_idx_i <= REG_ONE_SYM;
    cfg_data_i <= {8'd0, one};
    @(posedge clk_i);
    cfg_idx_i <= REG_ZERO_SYM;
    cfg_data_i <= {8'd0, zero};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    int       ph;
    int       len;
    int       lim;
    int       n;
    int       nd;
    int       d;
    int       phase_start;
    bit       pressure_done;
    logic [9:0] p;
    logic [9:0] e;
    logic [2:0] c;

    pressure_done = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed: reset settings, strip length still zero
    send_cmd(CMD_START, '0, '0, '0, 1'b0);          // start refused, zero length
    send_cmd(CMD_DRAINED, '0, '0, '0, 1'b0);        // drained while idle, silent
    send_cmd(CMD_STOP, '0, '0, '0, 1'b0);           // stop while idle still answers
    send_cmd(CMD_WRITE, '0, '0, 24'hFFFFFF, 1'b0);  // outside the strip, ignored
    send_cmd(CMD_FILL, '0, 10'd1023, 24'hFFFFFF, 1'b0);
    send_cmd(CMD_DRAINED + 3'd1, 10'h3FF, 10'h3FF, 24'hFFFFFF, 1'b1);  // unknown codes
    send_cmd(CMD_DRAINED + 3'd3, 10'h3FF, 10'h3FF, 24'hFFFFFF, 1'b1);

    // --- directed: full strip, all-ones and all-zeros patterns
    set_registers(11'd1024, 3'd7, 3'd0);
    send_cmd(CMD_WRITE, 10'd0, '0, 24'hFFFFFF, 1'b0);
    send_cmd(CMD_WRITE, 10'd1023, '0, 24'hA5C33C, 1'b0);
    send_cmd(CMD_FILL, 10'd1, 10'd3, 24'h5A3CC3, 1'b0);
    send_cmd(CMD_FILL, 10'd10, 10'd5, 24'h123456, 1'b0);  // start past end, no effect
    send_cmd(CMD_START, '0, '0, '0, 1'b0);
    send_cmd(CMD_START, '0, '0, '0, 1'b0);                // busy while sending
    send_cmd(CMD_DRAINED, '0, '0, '0, 1'b1);
    send_cmd(CMD_DRAINED, '0, '0, '0, 1'b0);
    send_cmd(CMD_STOP, '0, '0, '0, 1'b0);                 // stop in mid frame

    // --- directed: one-pixel strip, inverted extremes, frame runs to its end
    set_registers(11'd1, 3'd0, 3'd7);
    send_cmd(CMD_WRITE, 10'd1, '0, 24'hFFFFFF, 1'b0);     // past the strip
    send_cmd(CMD_WRITE, 10'd0, '0, 24'h00FF00, 1'b0);
    send_cmd(CMD_FILL, 10'd0, 10'd1023, 24'h0F0F0F, 1'b0); // end clamped to the strip
    send_cmd(CMD_START, '0, '0, '0, 1'b0);                // pixel then zero padding
    send_cmd(CMD_DRAINED, '0, '0, '0, 1'b0);              // padding drained, wait stop
    send_cmd(CMD_START, '0, '0, '0, 1'b0);                // busy in wait stop
    send_cmd(CMD_DRAINED, '0, '0, '0, 1'b1);              // frame done
    send_cmd(CMD_DRAINED, '0, '0, '0, 1'b1);              // idle again, silent

    // --- random phases: mostly well-formed frames with random content
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < NUM_PHASES / 3) begin
        tx_idle_pct <= 10;
        rx_idle_pct <= 64;
      end else if (ph < 2 * NUM_PHASES / 3) begin
        tx_idle_pct <= 64;
        rx_idle_pct <= 10;
      end else begin
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
      end
      case (ph)
        0:       len = 12;    // long enough to keep draining through the hold-off
        5:       len = 1024;
        9:       len = 0;
        default: len = $urandom_range(1, 12);
      endcase
      set_registers(11'(len), 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
      lim = (len > 1023) ? 1023 : len;
      phase_start = items_sent;

      while (items_sent - phase_start < PHASE_ITEMS) begin
        // pixel content, now and then just outside the strip
        n = $urandom_range(0, 4);
        repeat (n) begin
          p = ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(0, lim));
          if ($urandom_range(1) == 0) begin
            send_cmd(CMD_WRITE, p, 10'($urandom), 24'($urandom), 1'($urandom));
          end else begin
            e = ($urandom_range(7) == 0) ? 10'($urandom) : p + 10'($urandom_range(0, 6));
            send_cmd(CMD_FILL, p, e, 24'($urandom), 1'($urandom));
          end
        end

        send_cmd(CMD_START, 10'($urandom), 10'($urandom), 24'($urandom), 1'($urandom));
        if (!pressure_done) begin
          // stall the result side while drained events keep coming
          hold_ticket <= hold_ticket + 1;
          pressure_done = 1'b1;
        end
        if ($urandom_range(7) == 0)
          send_cmd(CMD_START, 10'($urandom), 10'($urandom), 24'($urandom), 1'($urandom));

        // enough drained events to finish a short frame, sometimes a few short
        nd = (len > 16) ? $urandom_range(1, 4) : len / 2 + $urandom_range(0, 3);
        for (d = 0; d < nd; d++) begin
          if ($urandom_range(7) == 0)
            send_cmd(CMD_WRITE, 10'($urandom_range(0, lim)), 10'($urandom), 24'($urandom),
                     1'($urandom));
          send_cmd(CMD_DRAINED, 10'($urandom), 10'($urandom), 24'($urandom),
                   ($urandom_range(7) == 0) ? 1'($urandom) : 1'(d % 2));
        end
        if ($urandom_range(2) == 0)
          send_cmd(CMD_STOP, 10'($urandom), 10'($urandom), 24'($urandom), 1'($urandom));

        // noise: any code with any fields
        if ($urandom_range(5) == 0) begin
          c = 3'($urandom);
          send_cmd(c, 10'($urandom), 10'($urandom), 24'($urandom), 1'($urandom));
        end
      end
      send_cmd(CMD_STOP, '0, '0, '0, 1'b0);
    end

    // drain everything still owed, then give the block time to show stray output
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (100) @(posedge clk_i);

    $display("checked %0d commands, %0d spi bytes and %0d status words", cmd_total,
             byte_total, status_total);
    $display("over %0d register settings with stalls on both sides and one long hold-off",
             settings_used);
    if (error_total == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #8000000;
    $display("timeout with %0d results still owed", pending_results);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
hdl/lsse_pkg.sv
hdl/lsse_ram.sv
hdl/lsse_byte_enc.sv
hdl/led_strip_spi_symbol_encoder.sv
test/led_strip_spi_symbol_encoder_checker.sv
test/led_strip_spi_symbol_encoder_tb.sv
